// ===== rtl/ecb_pkg.sv =====
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared types and constants for the event counter bank.
// ----------------------------------------------------------------------------
package ecb_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int EVENT_BITS_DEF = 5;

    localparam int CMD_W   = 3;
    localparam int EV_W    = 5;
    localparam int DELTA_W = 32;
    localparam int CNT_W   = 64;
    localparam int SLOTS_W = 4;
    localparam int CODES_W = 40;

    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUMULATE = 3'd0,
        CMD_READ       = 3'd1,
        CMD_START      = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd_e;

    // register index is paddr[3] (8-byte spacing)
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_EVENT_CODES  = 1'b1;

    typedef struct packed {
        logic                 fire;
        t_cmd_e               cmd;
        logic [EV_W-1:0]      ev;
        logic [DELTA_W-1:0]   delta;
    } t_op;

endpackage

// ===== rtl/ecb_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ecb_cmd_if
// Command channel: valid/ready with one command per beat.
// ----------------------------------------------------------------------------
interface ecb_cmd_if import ecb_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [EV_W-1:0]    event_code;
    logic [DELTA_W-1:0] delta;

    modport source (output valid, output command, output event_code, output delta,
                    input ready);
    modport sink   (input valid, input command, input event_code, input delta,
                    output ready);
endinterface

// ===== rtl/ecb_res_if.sv =====
// ----------------------------------------------------------------------------
// ecb_res_if
// Result channel: valid/ready with one read value per beat.
// ----------------------------------------------------------------------------
interface ecb_res_if import ecb_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink   (input valid, input read_value, output ready);
endinterface

// ===== rtl/event_counter_bank_unit.sv =====
// ----------------------------------------------------------------------------
// event_counter_bank_unit
// Bank of programmable 64-bit event counters with an APB-style config port.
// ----------------------------------------------------------------------------
// Pipeline: the command beat is captured in the input register, then match/add
//   into the result register; a stalled result register holds it in the input register.
// Throughput: one command per cycle unless the result channel stalls; the slot match and 64-bit add fit one stage.
// Reset (sync, active low): counts zero, all slots enabled, slots_in_use and
//   event codes zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
module event_counter_bank_unit import ecb_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int EVENT_BITS = EVENT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecb_cmd_if.sink           i_cmd,
    ecb_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [SLOTS_W-1:0] r_slots;
    logic [CODES_W-1:0] r_codes;

    logic               r_in_vld;
    logic [CMD_W-1:0]   r_in_cmd;
    logic [EV_W-1:0]    r_in_ev;
    logic [DELTA_W-1:0] r_in_delta;

    logic               r_out_vld;
    logic [CNT_W-1:0]   r_out_value;

    logic               adv;
    t_op                op;
    logic [CNT_W-1:0]   bank_value;
    logic               cfg_wr;

    // ---- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_codes <= '0;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_SLOTS_IN_USE: r_slots <= pwdata[SLOTS_W-1:0];
                REG_EVENT_CODES:  r_codes <= pwdata[CODES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_SLOTS_IN_USE: prdata = APB_DW'(r_slots);
            REG_EVENT_CODES:  prdata = APB_DW'(r_codes);
            default:          prdata = '0;
        endcase
    end

    // ---- pipeline control
    assign adv         = !r_out_vld || o_res.ready;
    assign i_cmd.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_cmd   <= i_cmd.command;
            r_in_ev    <= i_cmd.event_code;
            r_in_delta <= i_cmd.delta;
        end
    end

    assign op.fire  = r_in_vld && adv;
    assign op.cmd   = t_cmd_e'(r_in_cmd);
    assign op.ev    = r_in_ev;
    assign op.delta = r_in_delta;

    ecb_slot_bank #(
        .NUM_SLOTS  (NUM_SLOTS),
        .EVENT_BITS (EVENT_BITS)
    ) u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slots      (r_slots),
        .i_codes      (r_codes),
        .i_op         (op),
        .o_read_value (bank_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (op.fire) begin
            r_out_value <= bank_value;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.read_value = r_out_value;

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_cmd.ready)
        else $error("command stalled with empty result register");

    a_stage_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op.fire |=> r_out_vld)
        else $error("executed command produced no result");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld && $stable(r_in_cmd) && $stable(r_in_delta))
        else $error("input register lost a stalled command");

endmodule

// ===== rtl/ecb_slot_bank.sv =====
// ----------------------------------------------------------------------------
// ecb_slot_bank
// Counter and enable storage with the parallel event match; executes one
// command per fire.
// ----------------------------------------------------------------------------
module ecb_slot_bank import ecb_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int EVENT_BITS = EVENT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SLOTS_W-1:0] i_slots,
    input  logic [CODES_W-1:0] i_codes,
    input  t_op                i_op,
    output logic [CNT_W-1:0]   o_read_value
);

    localparam int EXT_W = NUM_SLOTS * EVENT_BITS + CODES_W;

    logic [CNT_W-1:0]     r_counts [NUM_SLOTS];
    logic [CNT_W-1:0]     n_counts [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_enables;
    logic [NUM_SLOTS-1:0] n_enables;

    // slots past the packed register see code zero
    logic [EXT_W-1:0]      codes_ext;
    logic [EVENT_BITS-1:0] ev_ext;
    logic [NUM_SLOTS-1:0]  rd_match, acc_match, rd_hit, acc_hit;
    logic [CNT_W-1:0]      rd_value;

    assign codes_ext = {{(NUM_SLOTS * EVENT_BITS){1'b0}}, i_codes};
    assign ev_ext    = EVENT_BITS'(i_op.ev);

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_match
        assign rd_match[g] = (SLOTS_W'(g) < i_slots) &&
                             (codes_ext[g*EVENT_BITS +: EVENT_BITS] == ev_ext);
    end

    assign acc_match = rd_match & r_enables;
    // isolate lowest set bit = first matching slot
    assign rd_hit    = rd_match & (~rd_match + NUM_SLOTS'(1));
    assign acc_hit   = acc_match & (~acc_match + NUM_SLOTS'(1));

    always_comb begin
        rd_value = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            rd_value = rd_value | (rd_hit[i] ? r_counts[i] : '0);
        end
    end

    assign o_read_value = (i_op.cmd == CMD_READ) ? rd_value : '0;

    always_comb begin
        n_counts  = r_counts;
        n_enables = r_enables;
        if (i_op.fire) begin
            case (i_op.cmd)
                CMD_ACCUMULATE: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (acc_hit[i]) begin
                            n_counts[i] = r_counts[i] + CNT_W'(i_op.delta);
                        end
                    end
                end
                CMD_START: begin
                    n_enables = '1;
                end
                CMD_STOP: begin
                    n_enables = '0;
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        n_counts[i] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_counts[i] <= '0;
            end
            r_enables <= '1;
        end else begin
            r_counts  <= n_counts;
            r_enables <= n_enables;
        end
    end

    a_stop_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.fire && i_op.cmd == CMD_STOP |=> r_enables == '0)
        else $error("enables not cleared after stop");

    a_start_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.fire && i_op.cmd == CMD_START |=> r_enables == '1)
        else $error("enables not set after start");

    a_acc_keeps_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.fire && i_op.cmd == CMD_ACCUMULATE |=> r_enables == $past(r_enables))
        else $error("accumulate changed enables");

    a_read_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.cmd == CMD_READ && rd_match == '0 |-> o_read_value == '0)
        else $error("unmatched read returned nonzero");

endmodule
